// ----- rtl/core/khp_pkg.sv -----
// Shared types and constants for the k-smallest max-heap block.
// Holds the request and response item layouts, the heap entry layout and the codes.
// Depends on nothing.
package khp_pkg;

    localparam int KEY_W   = 32;
    localparam int TAG_W   = 20;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_REPLACE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_value;
        logic [TAG_W-1:0] item_tag;
        logic [POS_W-1:0] position;
    } request_t;

    typedef struct packed {
        logic [KEY_W-1:0]   top_key;
        logic [TAG_W-1:0]   top_tag;
        logic [COUNT_W-1:0] entry_count;
        logic [KEY_W-1:0]   read_key;
        logic [TAG_W-1:0]   read_tag;
        logic               replaced;
        logic [1:0]         status;
    } response_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

endpackage

// ----- rtl/core/khp_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
// Depends on nothing.
module khp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/k_smallest_max_heap.sv -----
// Top level of the k-smallest max-heap: control sequencer around the heap memory.
// Depends on khp_pkg and khp_ram.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------
//   request   | start high, busy low | request  (khp_pkg::request_t)
//   result    | done, one cycle      | result   (khp_pkg::response_t)
//
// A read, an ignored or refused item and an insert into the empty heap go straight from
// acceptance to the finish state. Any other insert climbs from the new slot, one level
// at a time, until its key no longer beats the parent or it reaches the root; a replace
// that overwrites the root descends one level at a time until no child has a greater
// key. The pace of both is set by the single heap memory:
// each level is one registered read of the parent or both children and one write.
// Reset clears only the fill count and the control; heap slots above the count are
// never used, so the memory needs no clearing pass. The result cannot be stalled:
// done is high for one cycle, and busy falls in that same cycle.
module k_smallest_max_heap #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  khp_pkg::request_t   request,
    output logic                done,
    output khp_pkg::response_t  result
);

    import khp_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = ADDR_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN,
        ST_PLACE,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  slot_reg, slot_next;
    entry_t             entry_reg, entry_next;
    entry_t             top_reg;
    logic               replaced_reg, replaced_next;
    logic [1:0]         status_reg, status_next;
    logic               read_ok_reg, read_ok_next;
    logic               done_reg, done_next;
    response_t          result_reg, result_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr_a, ram_raddr_b;
    entry_t             ram_rdata_a, ram_rdata_b;

    // Heap index arithmetic, slot 0 is the root.
    logic [ADDR_W-1:0]  ins_slot;
    logic [ADDR_W-1:0]  up_slot;
    logic [ADDR_W-1:0]  ins_parent, up_parent;
    logic [IDX_W-1:0]   left_idx, right_idx;
    logic               left_ok, right_ok;
    logic               take_left, take_right;
    logic [KEY_W-1:0]   left_or_entry_key;
    logic [ADDR_W-1:0]  best_slot;
    logic [IDX_W-1:0]   best_left, best_right;
    logic               pos_ok;

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] d;
        d = a - ADDR_W'(1);
        return d >> 1;
    endfunction

    assign ins_slot   = ADDR_W'(count_reg);
    assign ins_parent = parent_of(ins_slot);
    assign up_slot    = parent_of(slot_reg);
    assign up_parent  = parent_of(up_slot);

    // Children of the current hole in the sift-down.
    assign left_idx  = {1'b0, slot_reg, 1'b1};
    assign right_idx = left_idx + IDX_W'(1);
    assign left_ok   = left_idx < IDX_W'(count_reg);
    assign right_ok  = right_idx < IDX_W'(count_reg);

    // A child moves up only on a strictly greater key; the left child wins ties.
    always_comb
    begin
        take_left         = left_ok && (ram_rdata_a.key > entry_reg.key);
        left_or_entry_key = take_left ? ram_rdata_a.key : entry_reg.key;
        take_right        = right_ok && (ram_rdata_b.key > left_or_entry_key);
        if (take_right)
        begin
            best_slot = right_idx[ADDR_W-1:0];
        end
        else
        begin
            best_slot = left_idx[ADDR_W-1:0];
        end
    end

    assign best_left  = {1'b0, best_slot, 1'b1};
    assign best_right = best_left + IDX_W'(1);

    assign pos_ok = COUNT_W'(request.position) < COUNT_W'(count_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        entry_next    = entry_reg;
        replaced_next = replaced_reg;
        status_next   = status_reg;
        read_ok_next  = read_ok_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_reg;
        ram_wdata     = entry_reg;
        ram_raddr_a   = up_slot;
        ram_raddr_b   = up_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    replaced_next = 1'b0;
                    status_next   = STATUS_OK;
                    read_ok_next  = 1'b0;
                    entry_next    = '{key: request.key_value, tag: request.item_tag};
                    state_next    = ST_FINISH;
                    case (request.kind)
                        KIND_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                slot_next  = ins_slot;
                                if (ins_slot == '0)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    ram_wdata = '{key: request.key_value,
                                                  tag: request.item_tag};
                                end
                                else
                                begin
                                    ram_raddr_a = ins_parent;
                                    state_next  = ST_UP;
                                end
                            end
                        end
                        KIND_REPLACE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else if (top_reg.key > request.key_value)
                            begin
                                replaced_next = 1'b1;
                                slot_next     = '0;
                                ram_raddr_a   = ADDR_W'(1);
                                ram_raddr_b   = ADDR_W'(2);
                                state_next    = ST_DOWN;
                            end
                        end
                        KIND_READ:
                        begin
                            ram_raddr_a  = ADDR_W'(request.position);
                            read_ok_next = pos_ok;
                            if (!pos_ok)
                            begin
                                status_next = STATUS_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_UP:
            begin
                // The parent arrived; move it down into the hole if the new key wins.
                ram_we = 1'b1;
                if (entry_reg.key > ram_rdata_a.key)
                begin
                    ram_wdata = ram_rdata_a;
                    slot_next = up_slot;
                    if (up_slot == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram_raddr_a = up_parent;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DOWN:
            begin
                ram_we = 1'b1;
                if (take_left || take_right)
                begin
                    ram_wdata   = take_right ? ram_rdata_b : ram_rdata_a;
                    slot_next   = best_slot;
                    ram_raddr_a = best_left[ADDR_W-1:0];
                    ram_raddr_b = best_right[ADDR_W-1:0];
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_PLACE:
            begin
                ram_we     = 1'b1;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                done_next               = 1'b1;
                result_next.top_key     = (count_reg != '0) ? top_reg.key : '0;
                result_next.top_tag     = (count_reg != '0) ? top_reg.tag : '0;
                result_next.entry_count = COUNT_W'(count_reg);
                result_next.read_key    = read_ok_reg ? ram_rdata_a.key : '0;
                result_next.read_tag    = read_ok_reg ? ram_rdata_a.tag : '0;
                result_next.replaced    = replaced_reg;
                result_next.status      = status_reg;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            replaced_reg <= 1'b0;
            status_reg   <= STATUS_OK;
            read_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            replaced_reg <= replaced_next;
            status_reg   <= status_next;
            read_ok_reg  <= read_ok_next;
        end
    end

    // Payload registers; the root copy tracks every write to slot 0.
    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        entry_reg  <= entry_next;
        result_reg <= result_next;
        if (ram_we && (ram_waddr == '0))
        begin
            top_reg <= ram_wdata;
        end
    end

    khp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap fill count beyond capacity");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done_reg)
        else $error("busy dropped without a result");

    a_write_owned: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE || start))
        else $error("heap memory written while idle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == STATUS_FULL)
            |-> (result_reg.entry_count == COUNT_W'(CAPACITY)))
        else $error("full status reported below capacity");
`endif

endmodule
